@@ design/image_median_filter_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef IMAGE_MEDIAN_FILTER_CORE_ASSERT_SVH
`define IMAGE_MEDIAN_FILTER_CORE_ASSERT_SVH

// Clocked property, disabled while reset is asserted.
`define IMF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication form on the same clock and reset.
`define IMF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ design/imf_pkg.sv @@
package imf_pkg;

	localparam int PIX_W     = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd2;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_DRAIN = 1'b1;

	typedef struct packed {
		logic start;
		logic ack;
	} sel_ctl_t;

	typedef struct packed {
		logic done;
	} sel_sts_t;

endpackage

@@ design/imf_stream_if.sv @@
interface imf_in_if import imf_pkg::*;;
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [PIX_W-1:0] pixel_value;

	modport source (output valid, cmd, pixel_value, input ready);
	modport sink (input valid, cmd, pixel_value, output ready);
endinterface

interface imf_out_if import imf_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] filtered_pixel;
	logic             frame_end;

	modport source (output valid, filtered_pixel, frame_end, input ready);
	modport sink (input valid, filtered_pixel, frame_end, output ready);
endinterface

@@ design/imf_line_ram.sv @@
module imf_line_ram #(
	parameter int DEPTH = 6151,
	parameter int AW    = 13,
	parameter int DW    = 16
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ design/imf_select.sv @@
module imf_select import imf_pkg::*; #(
	parameter int MAX_RADIUS = 3,
	parameter int PIXEL_BITS = 16,
	parameter int WW         = 11,
	parameter int RW         = 2,
	parameter int AW         = 13,
	parameter int DEPTH      = 6151
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sel_ctl_t              ctl,
	output sel_sts_t              sts,
	input  logic [WW-1:0]         w,
	input  logic [15:0]           h,
	input  logic [RW-1:0]         r,
	input  logic [15:0]           orow,
	input  logic [WW-1:0]         ocol,
	input  logic [AW-1:0]         optr,
	output logic [AW-1:0]         rd_addr,
	input  logic [PIXEL_BITS-1:0] rd_data,
	output logic [PIXEL_BITS-1:0] result
);

	localparam int SIDE = 2 * MAX_RADIUS + 1;
	localparam int SW   = $clog2(SIDE);
	localparam int NMAX = SIDE * SIDE;
	localparam int NW   = $clog2(NMAX + 1);
	localparam int BW   = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;
	localparam int SGW  = ((WW > 16) ? WW : 16) + 2;
	localparam int AGW  = AW + 2;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_FLUSH  = 3'd2;
	localparam logic [2:0] S_DECIDE = 3'd3;
	localparam logic [2:0] S_HOLD   = 3'd4;

	logic [2:0]            state_q;
	logic [SW-1:0]         dr_q, dc_q;
	logic [NW-1:0]         k_q, k_hi_q, cnt0_q;
	logic [PIXEL_BITS-1:0] prefix_q, first_q, result_q;
	logic [BW-1:0]         bit_q;
	logic                  two_q, phase_q, vld_s1;

	logic [SW-1:0]         last_idx;
	logic signed [SGW-1:0] dr_off, dc_off, row_s, col_s, h_s, w_s;
	logic signed [AGW-1:0] dr_a, dc_a, w_a, sum_a, dep_a, addr_a;
	logic                  in_img;
	logic [16:0]           lo_r, hi_r, lo_c, hi_c;
	logic [NW-1:0]         rows_n, cols_n, n_win;
	logic [PIXEL_BITS-1:0] hi_mask, bit_mask, new_pref;
	logic                  take_one;
	logic [NW-1:0]         k_new;
	logic [PIXEL_BITS:0]   avg_sum;

	assign last_idx = SW'({r, 1'b0});

	always_comb begin
		dr_off = SGW'(dr_q) - SGW'(r);
		dc_off = SGW'(dc_q) - SGW'(r);
		row_s  = SGW'(orow) + dr_off;
		col_s  = SGW'(ocol) + dc_off;
		h_s    = SGW'(h);
		w_s    = SGW'(w);
		in_img = !row_s[SGW-1] && (row_s < h_s) && !col_s[SGW-1] && (col_s < w_s);
		dr_a   = AGW'(dr_off);
		dc_a   = AGW'(dc_off);
		w_a    = AGW'(w);
		dep_a  = AGW'(DEPTH);
		sum_a  = AGW'(optr) + dr_a * w_a + dc_a;
		if (sum_a < 0) begin
			addr_a = sum_a + dep_a;
		end else if (sum_a >= dep_a) begin
			addr_a = sum_a - dep_a;
		end else begin
			addr_a = sum_a;
		end
		rd_addr = AW'(addr_a);
	end

	always_comb begin
		lo_r   = (orow >= 16'(r)) ? 17'(orow) - 17'(r) : 17'd0;
		hi_r   = (17'(orow) + 17'(r) >= 17'(h) - 17'd1) ? 17'(h) - 17'd1 : 17'(orow) + 17'(r);
		lo_c   = (17'(ocol) >= 17'(r)) ? 17'(ocol) - 17'(r) : 17'd0;
		hi_c   = (17'(ocol) + 17'(r) >= 17'(w) - 17'd1) ? 17'(w) - 17'd1 : 17'(ocol) + 17'(r);
		rows_n = NW'(hi_r - lo_r + 17'd1);
		cols_n = NW'(hi_c - lo_c + 17'd1);
		n_win  = NW'(rows_n * cols_n);
	end

	always_comb begin
		hi_mask  = ({PIXEL_BITS{1'b1}} << bit_q) << 1;
		bit_mask = PIXEL_BITS'(1) << bit_q;
		take_one = (k_q >= cnt0_q);
		new_pref = take_one ? (prefix_q | bit_mask) : prefix_q;
		k_new    = take_one ? (k_q - cnt0_q) : k_q;
		avg_sum  = {1'b0, first_q} + {1'b0, new_pref};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vld_s1  <= 1'b0;
		end else begin
			vld_s1 <= (state_q == S_SCAN) && in_img;
			case (state_q)
				S_IDLE: begin
					if (ctl.start) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (dc_q == last_idx && dr_q == last_idx) begin
						state_q <= S_FLUSH;
					end
				end
				S_FLUSH: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (bit_q == '0 && !(two_q && !phase_q)) begin
						state_q <= S_HOLD;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_HOLD: begin
					if (ctl.ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && (((rd_data ^ prefix_q) & hi_mask) == '0) && !rd_data[bit_q]) begin
			cnt0_q <= cnt0_q + NW'(1);
		end
		case (state_q)
			S_IDLE: begin
				k_q      <= NW'((n_win - NW'(1)) >> 1);
				k_hi_q   <= n_win >> 1;
				two_q    <= !n_win[0];
				phase_q  <= 1'b0;
				prefix_q <= '0;
				bit_q    <= BW'(PIXEL_BITS - 1);
				cnt0_q   <= '0;
				dr_q     <= '0;
				dc_q     <= '0;
			end
			S_SCAN: begin
				if (dc_q == last_idx) begin
					dc_q <= '0;
					dr_q <= (dr_q == last_idx) ? '0 : dr_q + SW'(1);
				end else begin
					dc_q <= dc_q + SW'(1);
				end
			end
			S_DECIDE: begin
				cnt0_q <= '0;
				if (bit_q == '0) begin
					if (two_q && !phase_q) begin
						first_q  <= new_pref;
						phase_q  <= 1'b1;
						k_q      <= k_hi_q;
						prefix_q <= '0;
						bit_q    <= BW'(PIXEL_BITS - 1);
					end else begin
						result_q <= phase_q ? PIXEL_BITS'(avg_sum >> 1) : new_pref;
					end
				end else begin
					prefix_q <= new_pref;
					k_q      <= k_new;
					bit_q    <= bit_q - BW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.done = (state_q == S_HOLD);
	assign result   = result_q;

endmodule

@@ design/image_median_filter_core.sv @@
// Streaming 2-D median filter over greyscale frames in raster order.
// in_ch carries one item per transfer: cmd = pixel or drain, and a pixel value.
// out_ch carries the filtered pixel and a frame_end flag on the frame's last one.
// Outputs trail the inputs by R*W+R pixels; after the last pixel, one drain
// item per remaining output flushes the frame. Config writes (cfg_we, cfg_index,
// cfg_data) set width, height and radius and restart the frame; write only
// while idle.
// An item with an output runs a radix select: one pass over the window per
// result bit, one line store read per window slot per cycle, and a second
// search for an even window count, whose two middle values are averaged.
// The window is S by S, S = 2*R+1 with R the configured radius.
// in_ch.ready is low while a median is being computed. A finished result sits
// in the output register; if out_ch stalls, the next median waits for it.
// Reset clears counters and registers to width 1024, height 1024, radius 1;
// line store contents are not cleared.
module image_median_filter_core import imf_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_RADIUS = 3,
	parameter int PIXEL_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	imf_in_if.sink               in_ch,
	imf_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int DEPTH = 2 * MAX_RADIUS * MAX_WIDTH + 2 * MAX_RADIUS + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int LW    = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic [10:0]           width_q;
	logic [15:0]           height_q;
	logic [1:0]            radius_q;
	logic                  state_q;
	logic [15:0]           in_row_q, out_row_q;
	logic [WW-1:0]         in_col_q, out_col_q;
	logic [AW-1:0]         wp_q, optr_q;
	logic [LW-1:0]         cnt_q;
	logic                  out_valid_q, out_end_q;
	logic [PIX_W-1:0]      out_pix_q;

	logic [WW-1:0]         w_eff;
	logic [15:0]           h_eff;
	logic [RW-1:0]         r_eff;
	logic [LW-1:0]         lag;
	logic                  accept, complete, is_pix, start, take, last, cfg_hit;
	logic [PIXEL_BITS-1:0] rd_data, result;
	logic [AW-1:0]         rd_addr;
	sel_ctl_t              ctl;
	sel_sts_t              sts;

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff = (height_q == '0) ? 16'd1 : height_q;
		r_eff = (32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);
		lag   = LW'(LW'(r_eff) * LW'(w_eff)) + LW'(r_eff);
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign complete    = (in_row_q >= h_eff);
	assign is_pix      = (in_ch.cmd == CMD_PIXEL) && !complete;
	assign start       = accept && (complete || (is_pix && cnt_q == lag));
	assign take        = (state_q == ST_BUSY) && sts.done && (!out_valid_q || out_ch.ready);
	assign last        = (({1'b0, out_col_q} + 1'b1) >= {1'b0, w_eff})
		&& ((17'(out_row_q) + 17'd1) >= 17'(h_eff));
	assign cfg_hit     = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT
		|| cfg_index == CFG_RADIUS);

	assign ctl.start = start;
	assign ctl.ack   = take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 11'd1024;
			height_q    <= 16'd1024;
			radius_q    <= 2'd1;
			state_q     <= ST_IDLE;
			in_row_q    <= '0;
			in_col_q    <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			wp_q        <= '0;
			optr_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_hit) begin
				case (cfg_index)
					CFG_WIDTH:  width_q  <= cfg_data[10:0];
					CFG_HEIGHT: height_q <= cfg_data[15:0];
					CFG_RADIUS: radius_q <= cfg_data[1:0];
					default: begin
					end
				endcase
				in_row_q  <= '0;
				in_col_q  <= '0;
				out_row_q <= '0;
				out_col_q <= '0;
				wp_q      <= '0;
				optr_q    <= '0;
				cnt_q     <= '0;
			end else if (take) begin
				state_q     <= ST_IDLE;
				out_valid_q <= 1'b1;
				if (last) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					wp_q      <= '0;
					optr_q    <= '0;
					cnt_q     <= '0;
				end else begin
					optr_q <= (optr_q == AW'(DEPTH - 1)) ? '0 : optr_q + AW'(1);
					if (({1'b0, out_col_q} + 1'b1) >= {1'b0, w_eff}) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + 16'd1;
					end else begin
						out_col_q <= out_col_q + WW'(1);
					end
				end
			end else if (accept) begin
				if (start) begin
					state_q <= ST_BUSY;
				end
				if (is_pix) begin
					wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
					if (cnt_q != lag) begin
						cnt_q <= cnt_q + LW'(1);
					end
					if (({1'b0, in_col_q} + 1'b1) >= {1'b0, w_eff}) begin
						in_col_q <= '0;
						in_row_q <= in_row_q + 16'd1;
					end else begin
						in_col_q <= in_col_q + WW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_pix_q <= PIX_W'(result);
			out_end_q <= last;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.filtered_pixel = out_pix_q;
	assign out_ch.frame_end      = out_end_q;

	imf_line_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (PIXEL_BITS)
	) u_ram (
		.clk   (clk),
		.we    (accept && is_pix),
		.waddr (wp_q),
		.wdata (in_ch.pixel_value[PIXEL_BITS-1:0]),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	imf_select #(
		.MAX_RADIUS (MAX_RADIUS),
		.PIXEL_BITS (PIXEL_BITS),
		.WW         (WW),
		.RW         (RW),
		.AW         (AW),
		.DEPTH      (DEPTH)
	) u_sel (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.sts     (sts),
		.w       (w_eff),
		.h       (h_eff),
		.r       (r_eff),
		.orow    (out_row_q),
		.ocol    (out_col_q),
		.optr    (optr_q),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.result  (result)
	);

endmodule

@@ design/imf_checker.sv @@
`include "image_median_filter_core_assert.svh"

module imf_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready
);

	`IMF_ASSERT(a_out_hold, (out_valid && !out_ready) |=> out_valid, "out valid dropped")
	`IMF_ASSERT_IMPL(a_out_after_busy, $rose(out_valid), $past(!in_ready), "result without work")
	`IMF_ASSERT_IMPL(a_busy_cause, $fell(in_ready), $past(in_valid && in_ready), "busy w/o transfer")

endmodule

bind image_median_filter_core imf_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready)
);
